[rtl/i2cee_pkg.sv]
package i2cee_pkg;

   // item kinds carried on req_tuser
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_PUSH  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   // completion codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NACK   = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   // configuration register indexes
   localparam logic CSR_BOUNDARY = 1'b0;
   localparam logic CSR_OVERRIDE = 1'b1;

   // upper nibble of the device select byte
   localparam logic [3:0] CTRL_HI = 4'hA;

   localparam int CNT_W  = 16;
   localparam int BND_W  = 12;
   localparam int ADDR_W = 11;

   typedef struct packed {
      logic       scl;
      logic       sda_release;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       read_last;
      logic       done_res;
      logic [1:0] status;
      logic       busy_res;
   } result_type;

endpackage

[rtl/i2cee_store.sv]
module i2cee_store #(
   parameter int WRITE_DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [7:0]       wr_data,
   input  logic [IDX_W-1:0] rd_idx,
   output logic [7:0]       rd_data
);

   logic [7:0] mem_ff [WRITE_DEPTH];
   logic [7:0] rd_data_ff;

   // write buffer; read port is registered and follows the send pointer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/i2cee_seq.sv]
module i2cee_seq import i2cee_pkg::*; #(
   parameter int WRITE_DEPTH = 16,
   parameter int ADDR_BITS = 11,
   parameter int FILL_W = 5,
   parameter int IDX_W = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [1:0]           action,
   input  logic [ADDR_BITS-1:0] address,
   input  logic [CNT_W-1:0]     count,
   input  logic                 sda_in,
   input  logic [BND_W-1:0]     protect_boundary,
   input  logic                 protect_override,
   input  logic [7:0]           store_rd_data,
   output logic                 store_wr_en,
   output logic [IDX_W-1:0]     store_wr_idx,
   output logic [IDX_W-1:0]     store_rd_idx,
   output result_type           result
);

   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_START     = 4'd1;
   localparam logic [3:0] PH_CTRL      = 4'd2;
   localparam logic [3:0] PH_CTRL_ACK  = 4'd3;
   localparam logic [3:0] PH_ADDR      = 4'd4;
   localparam logic [3:0] PH_ADDR_ACK  = 4'd5;
   localparam logic [3:0] PH_DATA      = 4'd6;
   localparam logic [3:0] PH_DATA_ACK  = 4'd7;
   localparam logic [3:0] PH_RSTART    = 4'd8;
   localparam logic [3:0] PH_RCTRL     = 4'd9;
   localparam logic [3:0] PH_RCTRL_ACK = 4'd10;
   localparam logic [3:0] PH_RDATA     = 4'd11;
   localparam logic [3:0] PH_RACK      = 4'd12;
   localparam logic [3:0] PH_STOP_OK   = 4'd13;
   localparam logic [3:0] PH_STOP_NACK = 4'd14;

   logic [3:0]           phase_ff, phase_in;
   logic [1:0]           tick_ff, tick_in;
   logic [2:0]           bit_ff, bit_in;
   logic [7:0]           shift_ff, shift_in;
   logic [CNT_W-1:0]     left_ff, left_in;
   logic [ADDR_BITS-1:0] target_ff, target_in;
   logic                 is_read_ff, is_read_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [FILL_W-1:0]    send_ff, send_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in_nx;

   logic                 busy;
   logic                 last_tick;
   logic                 reject_wr;
   logic [ADDR_W-1:0]    target_wide;
   logic                 rv, rl, done;
   logic [7:0]           rb;
   logic [1:0]           st;

   assign busy        = (phase_ff != PH_IDLE);
   assign last_tick   = (tick_ff == 2'd3);
   assign target_wide = ADDR_W'(target_ff);
   assign reject_wr   = ((BND_W'(address) >= protect_boundary) && !protect_override) ||
                        (count == '0) || (count > CNT_W'(WRITE_DEPTH));

   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      left_in    = left_ff;
      target_in  = target_ff;
      is_read_in = is_read_ff;
      fill_in    = fill_ff;
      send_in    = send_ff;
      scl_in     = scl_ff;
      sda_in_nx  = sda_ff;
      store_wr_en = 1'b0;
      rv   = 1'b0;
      rb   = '0;
      rl   = 1'b0;
      done = 1'b0;
      st   = ST_OK;

      if (step) begin
         case (action)
            ACT_PUSH: begin
               if (!busy && (fill_ff < FILL_W'(WRITE_DEPTH))) begin
                  store_wr_en = 1'b1;
                  fill_in     = fill_ff + 1'b1;
               end
            end
            ACT_WRITE, ACT_READ: begin
               if (!busy) begin
                  if ((action == ACT_WRITE && reject_wr) ||
                      (action == ACT_READ && count == '0)) begin
                     done = 1'b1;
                     st   = ST_REJECT;
                     if (action == ACT_WRITE) begin
                        fill_in = '0;
                     end
                  end else begin
                     target_in  = address;
                     is_read_in = (action == ACT_READ);
                     left_in    = count;
                     send_in    = '0;
                     bit_in     = '0;
                     tick_in    = '0;
                     shift_in   = '0;
                     phase_in   = PH_START;
                  end
               end
            end
            default: begin
               if (busy) begin
                  scl_in    = (tick_ff < 2'd2);
                  sda_in_nx = 1'b1;
                  case (phase_ff)
                     PH_START, PH_RSTART: begin
                        sda_in_nx = (tick_ff == 2'd0);
                        if (last_tick) begin
                           shift_in = {CTRL_HI, target_wide[10:8], phase_ff == PH_RSTART};
                           phase_in = (phase_ff == PH_RSTART) ? PH_RCTRL : PH_CTRL;
                           bit_in   = '0;
                        end
                     end
                     PH_CTRL, PH_ADDR, PH_DATA, PH_RCTRL: begin
                        sda_in_nx = shift_ff[7];
                        if (last_tick) begin
                           shift_in = {shift_ff[6:0], 1'b0};
                           if (bit_ff == 3'd7) begin
                              bit_in   = '0;
                              phase_in = phase_ff + 4'd1;
                           end else begin
                              bit_in = bit_ff + 3'd1;
                           end
                        end
                     end
                     PH_CTRL_ACK, PH_ADDR_ACK, PH_DATA_ACK, PH_RCTRL_ACK: begin
                        // acknowledge sampled in the first unit
                        if (tick_ff == 2'd0) begin
                           shift_in = {7'd0, sda_in};
                        end
                        if (last_tick) begin
                           bit_in = '0;
                           if (shift_ff[0]) begin
                              phase_in = PH_STOP_NACK;
                           end else if (phase_ff == PH_CTRL_ACK) begin
                              shift_in = target_wide[7:0];
                              phase_in = PH_ADDR;
                           end else if (phase_ff == PH_ADDR_ACK) begin
                              if (is_read_ff) begin
                                 phase_in = PH_RSTART;
                              end else begin
                                 shift_in = store_rd_data;
                                 send_in  = send_ff + 1'b1;
                                 phase_in = PH_DATA;
                              end
                           end else if (phase_ff == PH_DATA_ACK) begin
                              left_in = left_ff - 1'b1;
                              if (left_ff == CNT_W'(1)) begin
                                 phase_in = PH_STOP_OK;
                              end else begin
                                 shift_in = store_rd_data;
                                 send_in  = send_ff + 1'b1;
                                 phase_in = PH_DATA;
                              end
                           end else begin
                              shift_in = '0;
                              phase_in = PH_RDATA;
                           end
                        end
                     end
                     PH_RDATA: begin
                        if (tick_ff == 2'd0) begin
                           shift_in = {shift_ff[6:0], sda_in};
                           if (bit_ff == 3'd7) begin
                              rv = 1'b1;
                              rb = {shift_ff[6:0], sda_in};
                              rl = (left_ff <= CNT_W'(1));
                           end
                        end
                        if (last_tick) begin
                           if (bit_ff == 3'd7) begin
                              bit_in   = '0;
                              phase_in = PH_RACK;
                           end else begin
                              bit_in = bit_ff + 3'd1;
                           end
                        end
                     end
                     PH_RACK: begin
                        // nack on the final byte
                        sda_in_nx = (left_ff <= CNT_W'(1));
                        if (last_tick) begin
                           if (left_ff <= CNT_W'(1)) begin
                              phase_in = PH_STOP_OK;
                           end else begin
                              left_in  = left_ff - 1'b1;
                              shift_in = '0;
                              bit_in   = '0;
                              phase_in = PH_RDATA;
                           end
                        end
                     end
                     default: begin
                        scl_in    = 1'b1;
                        sda_in_nx = (tick_ff != 2'd0);
                        if (last_tick) begin
                           done = 1'b1;
                           st   = (phase_ff == PH_STOP_NACK) ? ST_NACK : ST_OK;
                           if (!is_read_ff) begin
                              fill_in = '0;
                           end
                           left_in  = '0;
                           phase_in = PH_IDLE;
                        end
                     end
                  endcase
                  tick_in = last_tick ? 2'd0 : tick_ff + 2'd1;
               end
            end
         endcase
      end

      result.scl         = scl_in;
      result.sda_release = sda_in_nx;
      result.read_valid  = rv;
      result.read_byte   = rb;
      result.read_last   = rl;
      result.done_res    = done;
      result.status      = st;
      result.busy_res    = (phase_in != PH_IDLE);
   end

   assign store_wr_idx = fill_ff[IDX_W-1:0];
   assign store_rd_idx = send_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         tick_ff    <= '0;
         bit_ff     <= '0;
         shift_ff   <= '0;
         left_ff    <= '0;
         target_ff  <= '0;
         is_read_ff <= 1'b0;
         fill_ff    <= '0;
         send_ff    <= '0;
         scl_ff     <= 1'b1;
         sda_ff     <= 1'b1;
      end else begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         left_ff    <= left_in;
         target_ff  <= target_in;
         is_read_ff <= is_read_in;
         fill_ff    <= fill_in;
         send_ff    <= send_in;
         scl_ff     <= scl_in;
         sda_ff     <= sda_in_nx;
      end
   end

endmodule

[rtl/i2c_eeprom_master_core.sv]
// a req item passes through the input register and then the result register before its rsp item is valid
// throughput: one item per cycle while rsp_tready is not held low; every item gives exactly one rsp item
// each tick item advances the bus sequencer by one 5 us unit, so a bus bit spans four ticks
// reset (synchronous, active high) idles the sequencer, releases scl and sda, empties the
// write buffer, sets protect_boundary to 2048 and clears protect_override
module i2c_eeprom_master_core import i2cee_pkg::*; #(
   parameter int WRITE_DEPTH = 16,
   parameter int ADDR_BITS = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // address, count, data_byte, sda_in, zero pad
   input  logic [((ADDR_BITS + CNT_W + 9 + 7) / 8) * 8 - 1:0] req_tdata,
   // action
   input  logic [1:0]             req_tuser,
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // scl, sda_release, read_valid, read_byte, done_res, status, busy_res, zero pad
   output logic [15:0]            rsp_tdata,
   // read_last
   output logic                   rsp_tlast,
   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [BND_W-1:0]       csr_data
);

   localparam int FILL_W      = $clog2(WRITE_DEPTH + 1);
   localparam int IDX_W       = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [1:0]           action_ff;
   logic [ADDR_BITS-1:0] address_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [7:0]           data_byte_ff;
   logic                 sda_in_ff;

   // result register
   logic                 out_valid_ff, out_valid_in;
   result_type           result_ff;
   result_type           result;

   // configuration registers
   logic [BND_W-1:0]     boundary_ff;
   logic                 override_ff;

   logic                 step;
   logic                 req_take;
   logic                 store_wr_en;
   logic [IDX_W-1:0]     store_wr_idx;
   logic [IDX_W-1:0]     store_rd_idx;
   logic [7:0]           store_rd_data;

   // the held item is processed whenever the result register is free or being drained
   assign step         = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || step;
   assign req_take     = req_tvalid && req_tready;
   assign in_valid_in  = req_take || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         action_ff    <= req_tuser;
         address_ff   <= req_tdata[ADDR_BITS-1:0];
         count_ff     <= req_tdata[ADDR_BITS+CNT_W-1:ADDR_BITS];
         data_byte_ff <= req_tdata[ADDR_BITS+CNT_W+7:ADDR_BITS+CNT_W];
         sda_in_ff    <= req_tdata[ADDR_BITS+CNT_W+8];
      end
      if (step) begin
         result_ff <= result;
      end
   end

   // configuration port never stalls
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         boundary_ff <= BND_W'(2048);
         override_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BOUNDARY: boundary_ff <= csr_data;
            CSR_OVERRIDE: override_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   i2cee_store #(
      .WRITE_DEPTH(WRITE_DEPTH),
      .IDX_W(IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_idx  (store_wr_idx),
      .wr_data (data_byte_ff),
      .rd_idx  (store_rd_idx),
      .rd_data (store_rd_data)
   );

   i2cee_seq #(
      .WRITE_DEPTH(WRITE_DEPTH),
      .ADDR_BITS(ADDR_BITS),
      .FILL_W(FILL_W),
      .IDX_W(IDX_W)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .action           (action_ff),
      .address          (address_ff),
      .count            (count_ff),
      .sda_in           (sda_in_ff),
      .protect_boundary (boundary_ff),
      .protect_override (override_ff),
      .store_rd_data    (store_rd_data),
      .store_wr_en      (store_wr_en),
      .store_wr_idx     (store_wr_idx),
      .store_rd_idx     (store_rd_idx),
      .result           (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff.busy_res, result_ff.status, result_ff.done_res,
                        result_ff.read_byte, result_ff.read_valid, result_ff.sda_release,
                        result_ff.scl};
   assign rsp_tlast  = result_ff.read_last;

endmodule
